FILE: rtl/biquad_iir_filter_core_macros.svh
// Assertion macros shared by the biquad checker.
// Depends on nothing; included by rtl/biquad_chk.sv.
`ifndef BIQUAD_IIR_FILTER_CORE_MACROS_SVH
`define BIQUAD_IIR_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/biquad_pkg.sv
// Shared constants and helpers for the biquad IIR filter core.
// Depends on nothing; used by the core and its checker.
package biquad_pkg;

   localparam int DEFAULT_SAMPLE_BITS = 16;
   localparam int COEFF_BITS          = 16;
   localparam int NUM_COEFFS          = 6;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int TAP_BITS            = 3;

   // Coefficient register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A0 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A1 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A2 = 3'd5;

   // Multiply-accumulate tap order
   localparam logic [TAP_BITS-1:0] TAP_B0    = 3'd0;
   localparam logic [TAP_BITS-1:0] TAP_B1    = 3'd1;
   localparam logic [TAP_BITS-1:0] TAP_B2    = 3'd2;
   localparam logic [TAP_BITS-1:0] TAP_A1    = 3'd3;
   localparam logic [TAP_BITS-1:0] TAP_A2    = 3'd4;
   localparam logic [TAP_BITS-1:0] TAP_DRAIN = 3'd5;

   localparam logic signed [COEFF_BITS-1:0] COEFF_UNITY = 16'sh7FFF;

   function automatic logic signed [COEFF_BITS-1:0] coeff_reset(
      input logic [CSR_INDEX_BITS-1:0] idx);
      logic signed [COEFF_BITS-1:0] val;
      begin
         val = '0;
         if (idx == REG_B0 || idx == REG_A0) begin
            val = COEFF_UNITY;
         end
         return val;
      end
   endfunction

endpackage

FILE: rtl/biquad_iir_filter_core.sv
// Biquad Direct Form I IIR filter core; uses biquad_pkg.
// An accepted req item passes through a multiply-accumulate tap sweep, a setup step,
// the restoring divider (one quotient bit per cycle) and a finish state that waits
// for the result register to free; req_stall holds off new items until it is idle.
// Reset restores the coefficients and clears the sample histories.
module biquad_iir_filter_core #(
   parameter int SAMPLE_BITS = biquad_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input sample channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                                   rsp_clipped,
   // coefficient write port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [biquad_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [biquad_pkg::COEFF_BITS-1:0]      csr_wdata
);

   // Product of a sample and a Q1.15 coefficient, and an accumulator that
   // holds five of them with headroom so it never wraps.
   localparam int CB     = biquad_pkg::COEFF_BITS;
   localparam int PROD_W = SAMPLE_BITS + CB;
   localparam int ACC_W  = SAMPLE_BITS + 19;
   localparam int STEP_W = $clog2(ACC_W);
   localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(biquad_pkg::TAP_DRAIN);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(ACC_W - 1);
   // Largest positive quotient magnitude and largest negative one
   localparam logic [ACC_W-1:0] POS_LIMIT =
      ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MAC    = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   // Sequencer
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Coefficients and histories
   logic signed [CB-1:0] coeff_ff [biquad_pkg::NUM_COEFFS];
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] x_d1_ff, x_d1_in, x_d2_ff, x_d2_in;
   logic signed [SAMPLE_BITS-1:0] y_d1_ff, y_d1_in, y_d2_ff, y_d2_in;

   // Multiply-accumulate datapath
   logic [biquad_pkg::TAP_BITS-1:0] tap_sel;
   logic signed [SAMPLE_BITS-1:0] mul_sample;
   logic signed [CB-1:0] mul_coeff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic prod_sub_ff, prod_sub_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Divider datapath
   logic [ACC_W-1:0] dvd_ff, dvd_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic [CB-1:0] div_ff, div_in;
   logic [CB+1:0] trial;
   logic acc_neg_ff, acc_neg_in, acc_nz_ff, acc_nz_in;
   logic a0_neg_ff, a0_neg_in, a0_zero_ff, a0_zero_in;
   logic signed [CB-1:0] a0_coeff;

   // Result stage
   logic signed [SAMPLE_BITS-1:0] y_res;
   logic clip_res;
   logic out_free;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_clip_ff, rsp_clip_in;

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   assign a0_coeff = coeff_ff[biquad_pkg::REG_A0];
   assign tap_sel  = step_ff[biquad_pkg::TAP_BITS-1:0];

   // Operand select for the shared multiplier
   always_comb begin
      mul_sample = '0;
      mul_coeff  = '0;
      unique case (tap_sel)
         biquad_pkg::TAP_B0: begin
            mul_sample = x_ff;
            mul_coeff  = coeff_ff[biquad_pkg::REG_B0];
         end
         biquad_pkg::TAP_B1: begin
            mul_sample = x_d1_ff;
            mul_coeff  = coeff_ff[biquad_pkg::REG_B1];
         end
         biquad_pkg::TAP_B2: begin
            mul_sample = x_d2_ff;
            mul_coeff  = coeff_ff[biquad_pkg::REG_B2];
         end
         biquad_pkg::TAP_A1: begin
            mul_sample = y_d1_ff;
            mul_coeff  = coeff_ff[biquad_pkg::REG_A1];
         end
         biquad_pkg::TAP_A2: begin
            mul_sample = y_d2_ff;
            mul_coeff  = coeff_ff[biquad_pkg::REG_A2];
         end
         default: begin
            mul_sample = '0;
            mul_coeff  = '0;
         end
      endcase
   end

   assign prod_in     = mul_sample * mul_coeff;
   assign prod_sub_in = (tap_sel == biquad_pkg::TAP_A1) || (tap_sel == biquad_pkg::TAP_A2);

   // Restoring division step: shift in the next dividend bit, try to subtract.
   assign trial = {1'b0, rem_ff, dvd_ff[ACC_W-1]} - {2'b00, div_ff};

   // Saturate the quotient magnitude by sign; a zero divisor follows the
   // sign of the accumulator.
   always_comb begin
      y_res    = '0;
      clip_res = 1'b0;
      if (a0_zero_ff) begin
         if (acc_nz_ff) begin
            clip_res = 1'b1;
            y_res    = acc_neg_ff ? SMIN : SMAX;
         end
      end else if (acc_neg_ff ^ a0_neg_ff) begin
         if (dvd_ff > NEG_LIMIT) begin
            clip_res = 1'b1;
            y_res    = SMIN;
         end else begin
            y_res = -$signed(dvd_ff[SAMPLE_BITS-1:0]);
         end
      end else begin
         if (dvd_ff > POS_LIMIT) begin
            clip_res = 1'b1;
            y_res    = SMAX;
         end else begin
            y_res = $signed(dvd_ff[SAMPLE_BITS-1:0]);
         end
      end
   end

   // The result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      x_in          = x_ff;
      x_d1_in       = x_d1_ff;
      x_d2_in       = x_d2_ff;
      y_d1_in       = y_d1_ff;
      y_d2_in       = y_d2_ff;
      acc_in        = acc_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      acc_neg_in    = acc_neg_ff;
      acc_nz_in     = acc_nz_ff;
      a0_neg_in     = a0_neg_ff;
      a0_zero_in    = a0_zero_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      // drop the result once the consumer takes it
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            // take a new sample and start the tap sweep
            if (req_valid) begin
               x_in     = req_sample_in;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // step k multiplies tap k; steps 1..5 fold in the product of step k-1
            if (step_ff == '0) begin
               acc_in = '0;
            end else if (prod_sub_ff) begin
               acc_in = acc_ff - ACC_W'(prod_ff);
            end else begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == MAC_LAST) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // split the division into magnitudes and signs
            acc_neg_in = acc_ff[ACC_W-1];
            acc_nz_in  = (acc_ff != '0);
            dvd_in     = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            a0_neg_in  = a0_coeff[CB-1];
            a0_zero_in = (a0_coeff == '0);
            div_in     = a0_coeff[CB-1] ? CB'(-a0_coeff) : CB'(a0_coeff);
            rem_in     = '0;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle, shifted into the dividend register
            if (trial[CB+1]) begin
               rem_in = {rem_ff[CB-2:0], dvd_ff[ACC_W-1]};
               dvd_in = {dvd_ff[ACC_W-2:0], 1'b0};
            end else begin
               rem_in = trial[CB-1:0];
               dvd_in = {dvd_ff[ACC_W-2:0], 1'b1};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register frees, then publish and advance history
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = y_res;
               rsp_clip_in   = clip_res;
               x_d2_in       = x_d1_ff;
               x_d1_in       = x_ff;
               y_d2_in       = y_d1_ff;
               y_d1_in       = y_res;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_d1_ff      <= '0;
         x_d2_ff      <= '0;
         y_d1_ff      <= '0;
         y_d2_ff      <= '0;
         for (int i = 0; i < biquad_pkg::NUM_COEFFS; i++) begin
            coeff_ff[i] <= biquad_pkg::coeff_reset(biquad_pkg::CSR_INDEX_BITS'(i));
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_d1_ff      <= x_d1_in;
         x_d2_ff      <= x_d2_in;
         y_d1_ff      <= y_d1_in;
         y_d2_ff      <= y_d2_in;
         // ignore indexes past the last coefficient
         if (csr_valid && (32'(csr_index) < biquad_pkg::NUM_COEFFS)) begin
            coeff_ff[csr_index] <= $signed(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      prod_sub_ff   <= prod_sub_in;
      acc_ff        <= acc_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      acc_neg_ff    <= acc_neg_in;
      acc_nz_ff     <= acc_nz_in;
      a0_neg_ff     <= a0_neg_in;
      a0_zero_ff    <= a0_zero_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

endmodule

FILE: rtl/biquad_chk.sv
// Port-level checker for the biquad IIR filter core, bound into the core module.
// Depends on biquad_pkg and biquad_iir_filter_core_macros.svh.
`include "biquad_iir_filter_core_macros.svh"

module biquad_chk #(
   parameter int SAMPLE_BITS = biquad_pkg::DEFAULT_SAMPLE_BITS
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [SAMPLE_BITS-1:0]                req_sample_in,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [SAMPLE_BITS-1:0]                rsp_sample_out,
   input logic                                  rsp_clipped,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic [biquad_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [biquad_pkg::COEFF_BITS-1:0]     csr_wdata
);

   localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic req_take;
   logic csr_take;
   logic unused_ok;

   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign unused_ok = ^{req_sample_in, csr_take, csr_index, csr_wdata};

   // The core works on one item at a time: busy right after taking one.
   `BQ_ASSERT_NXT(a_busy_after_take, clock, reset, req_take, req_stall,
      "core took a second item back to back")

   // A result cannot appear in the cycle after a new item is taken.
   `BQ_ASSERT_NXT(a_no_instant_rsp, clock, reset, req_take, !$rose(rsp_valid),
      "result appeared too early after an item was taken")

   // A clipped result sits at one of the range limits.
   `BQ_ASSERT_IMP(a_clip_at_limit, clock, reset, rsp_valid && rsp_clipped,
      (rsp_sample_out == SMAX) || (rsp_sample_out == SMIN),
      "clipped result is not at a range limit")

   // A stalled result stays presented.
   `BQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "result dropped while stalled")

endmodule

bind biquad_iir_filter_core biquad_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_biquad_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_sample_in  (req_sample_in),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_clipped    (rsp_clipped),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready),
   .csr_index      (csr_index),
   .csr_wdata      (csr_wdata)
);

FILE: tb/sv/tb.sv
// Self-checking bench for biquad_iir_filter_core: a shadow filter predicts each
// output sample and clipped flag, and every result item is checked against it.
// Depends on rtl/biquad_pkg.sv and rtl/biquad_iir_filter_core.sv.
module tb;
   import biquad_pkg::*;

   localparam int SB          = DEFAULT_SAMPLE_BITS;
   localparam int CYCLE_CAP   = 400000;
   localparam int SETTLE      = SB + 32;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 50;

   // Indexes past the coefficient file; writes there must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   typedef logic signed [SB-1:0]         sample_t;
   typedef logic signed [COEFF_BITS-1:0] coeff_t;
   typedef logic [COEFF_BITS-1:0]        coeff_bits_t;

   typedef struct {
      sample_t sample;
      logic    clipped;
   } filtered_t;

   typedef enum int {STYLE_STABLE, STYLE_WILD, STYLE_RAIL} coeff_style_e;

   localparam sample_t S_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam sample_t S_MIN = {1'b1, {(SB-1){1'b0}}};

   localparam int RAILS [5] = '{-32768, -1, 0, 1, 32767};

   // Shadow copy of the filter: coefficients, sample histories and the
   // output samples still owed by the block.
   class biquad_shadow;
      coeff_t    coeffs [NUM_COEFFS];
      sample_t   x_d1, x_d2, y_d1, y_d2;
      filtered_t due_samples [$];
      int        errors;

      function new();
         for (int i = 0; i < NUM_COEFFS; i++) coeffs[i] = '0;
         coeffs[REG_B0] = 16'sh7FFF;
         coeffs[REG_A0] = 16'sh7FFF;
         x_d1   = '0;
         x_d2   = '0;
         y_d1   = '0;
         y_d2   = '0;
         errors = 0;
      endfunction

      function void write_coeff(logic [CSR_INDEX_BITS-1:0] idx, coeff_bits_t val);
         if (idx < NUM_COEFFS) coeffs[idx] = coeff_t'(val);
      endfunction

      function void take_input(sample_t x);
         longint    acc, quo, hi_lim, lo_lim;
         filtered_t want;
         hi_lim = (longint'(1) <<< (SB - 1)) - 1;
         lo_lim = -hi_lim - 1;
         acc = longint'(coeffs[REG_B0]) * longint'(x)
             + longint'(coeffs[REG_B1]) * longint'(x_d1)
             + longint'(coeffs[REG_B2]) * longint'(x_d2)
             - longint'(coeffs[REG_A1]) * longint'(y_d1)
             - longint'(coeffs[REG_A2]) * longint'(y_d2);
         want.clipped = 1'b0;
         if (coeffs[REG_A0] == 0) begin
            // no divisor: rail by the sign of the sum, zero stays zero
            if (acc > 0) begin
               quo          = hi_lim;
               want.clipped = 1'b1;
            end else if (acc < 0) begin
               quo          = lo_lim;
               want.clipped = 1'b1;
            end else begin
               quo = 0;
            end
         end else begin
            quo = acc / longint'(coeffs[REG_A0]);
            if (quo > hi_lim) begin
               quo          = hi_lim;
               want.clipped = 1'b1;
            end else if (quo < lo_lim) begin
               quo          = lo_lim;
               want.clipped = 1'b1;
            end
         end
         want.sample = quo[SB-1:0];
         x_d2 = x_d1;
         x_d1 = x;
         y_d2 = y_d1;
         y_d1 = want.sample;
         due_samples.push_back(want);
      endfunction

      function void check_output(sample_t got_sample, logic got_clipped);
         filtered_t want;
         if (due_samples.size() == 0) begin
            $error("result item with none expected: sample_out %0d", got_sample);
            errors++;
            return;
         end
         want = due_samples.pop_front();
         if (got_sample !== want.sample) begin
            $error("sample_out: expected %0d, actual %0d", want.sample, got_sample);
            errors++;
         end
         if (got_clipped !== want.clipped) begin
            $error("clipped: expected %0b, actual %0b", want.clipped, got_clipped);
            errors++;
         end
      endfunction

      function int owed();
         return due_samples.size();
      endfunction
   endclass

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   sample_t                   req_sample_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   sample_t                   rsp_sample_out;
   logic                      rsp_clipped;
   logic                      csr_valid     = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index     = '0;
   coeff_bits_t               csr_wdata     = '0;

   bit                        quiet      = 1'b0;  // no idling on either side
   int                        stall_left = 0;
   int                        cycles     = 0;
   biquad_shadow              shadow;

   biquad_iir_filter_core #(
      .SAMPLE_BITS(SB)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .rsp_clipped   (rsp_clipped),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog: bail out if the run hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("biquad_iir_filter_core test failed");
         $finish;
      end
   end

   // Check every result item taken at this edge against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         shadow.check_output(rsp_sample_out, rsp_clipped);
      end
   end

   // Result-side back-pressure: start random stall bursts unless quiet.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one input item and hold it until taken. Leave valid high afterwards,
   // so that back-to-back items never see valid lowered and raised in one step.
   task automatic send_sample(input sample_t x);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.take_input(x);
   endtask

   // Drop valid and wait until every owed output has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (shadow.owed() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input coeff_bits_t val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.write_coeff(idx, val);
   endtask

   task automatic load_coeffs(input coeff_bits_t b0, input coeff_bits_t b1,
                              input coeff_bits_t b2, input coeff_bits_t a0,
                              input coeff_bits_t a1, input coeff_bits_t a2);
      write_reg(REG_B0, b0);
      write_reg(REG_B1, b1);
      write_reg(REG_B2, b2);
      write_reg(REG_A0, a0);
      write_reg(REG_A1, a1);
      write_reg(REG_A2, a2);
      csr_valid <= 1'b0;
   endtask

   function automatic coeff_bits_t rand_coeff(input int lo, input int hi);
      int v;
      v = lo + int'($urandom_range(0, hi - lo));
      return v[COEFF_BITS-1:0];
   endfunction

   function automatic coeff_bits_t rail_coeff();
      int v;
      v = RAILS[$urandom_range(0, 4)];
      return v[COEFF_BITS-1:0];
   endfunction

   // Mostly full-range samples, with rails and small values mixed in.
   function automatic sample_t rand_sample();
      logic [31:0] r;
      sample_t     x;
      r = $urandom;
      x = r[SB-1:0];
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: x = S_MAX;
               1: x = S_MIN;
               2: x = '0;
               default: x = '1;
            endcase
         end
         1: x = {{(SB-5){r[4]}}, r[4:0]};
         default: ;
      endcase
      return x;
   endfunction

   // One random phase: pick a coefficient set while idle, then stream items.
   task automatic random_phase(input int n_items);
      coeff_style_e style;
      coeff_bits_t  c [NUM_COEFFS];
      style = coeff_style_e'($urandom_range(0, 2));
      case (style)
         STYLE_STABLE: begin
            // well-behaved filter: modest feedback against a large divisor
            c[REG_B0] = rand_coeff(-8192, 8192);
            c[REG_B1] = rand_coeff(-8192, 8192);
            c[REG_B2] = rand_coeff(-8192, 8192);
            c[REG_A0] = $urandom_range(0, 3) == 0 ? rand_coeff(-32768, -16384)
                                                  : rand_coeff(16384, 32767);
            c[REG_A1] = rand_coeff(-16384, 16384);
            c[REG_A2] = rand_coeff(-8192, 8192);
         end
         STYLE_WILD: begin
            for (int i = 0; i < NUM_COEFFS; i++) c[i] = rand_coeff(-32768, 32767);
            case ($urandom_range(0, 3))
               0: c[REG_A0] = '0;
               1: c[REG_A0] = rand_coeff(-16, 16);
               default: ;
            endcase
         end
         default: begin
            for (int i = 0; i < NUM_COEFFS; i++) c[i] = rail_coeff();
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         write_reg($urandom_range(0, 1) == 1 ? REG_SPARE_HI : REG_SPARE_LO,
                   rand_coeff(-32768, 32767));
      end
      load_coeffs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A0], c[REG_A1], c[REG_A2]);
      for (int n = 0; n < n_items; n++) send_sample(rand_sample());
      settle();
   endtask

   initial begin
      shadow = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients: unity over unity passes samples straight through.
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(sample_t'(0));
      send_sample(sample_t'(1));
      send_sample(sample_t'(-1));
      settle();

      // Zero divisor: output rails by the sign of the sum, zero sum gives zero.
      // Also poke an unused index, which must leave the coefficients alone.
      write_reg(REG_SPARE_HI, 16'h1234);
      load_coeffs(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample(sample_t'(100));
      send_sample(sample_t'(-100));
      send_sample(sample_t'(0));
      settle();

      // Tiny divisor: the quotient overflows in both directions.
      load_coeffs(16'h7FFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
      send_sample(sample_t'(1000));
      send_sample(sample_t'(-1000));
      settle();

      // Every coefficient at its most negative value.
      load_coeffs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(S_MIN);
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample(S_MAX);
      settle();

      // Every coefficient at its most positive value.
      load_coeffs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(S_MAX);
      send_sample(S_MAX);
      send_sample(S_MAX);
      send_sample(S_MIN);
      settle();

      // Random phases; histories carry over between them. Run the last one
      // with no idling on either side.
      for (int p = 0; p < RAND_PHASES; p++) begin
         quiet = (p == RAND_PHASES - 1) || ($urandom_range(0, 4) == 0);
         random_phase(PHASE_ITEMS);
      end

      // Catch any stray result item after the last expected one.
      repeat (SETTLE) @(posedge clock);
      if (shadow.errors == 0 && shadow.owed() == 0) begin
         $display("biquad_iir_filter_core test passed");
      end else begin
         $display("biquad_iir_filter_core test failed");
      end
      $finish;
   end

endmodule
